// File: rtl/cdt_pkg.sv
// Shared types and codes for the countdown timer slot table.
// Holds the action and status codes and the packed beat structs; no dependencies.
package cdt_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned PeriodW = 10;
  localparam int unsigned DivW    = CountW + 1;  // dividend width after rounding add
  localparam int unsigned DivCntW = 6;           // holds DivW - 1

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_OPEN  = 2'd1,
    ACT_CLOSE = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NULL_KEY = 2'd1,
    STS_NO_SLOT  = 2'd2,
    STS_RSVD     = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    REG_TIMERS_ENABLED = 1'b0,
    REG_TICK_PERIOD_MS = 1'b1
  } reg_idx_e;

  typedef struct packed {
    action_e             action;
    logic [KeyW-1:0]     timer_key;
    logic [CountW-1:0]   duration_ms;
  } in_beat_t;

  typedef struct packed {
    status_e             status;
    logic [CountW-1:0]   remaining_ticks;
  } out_beat_t;

endpackage

// File: rtl/countdown_timer_slot_table_core.sv
// Countdown timer slot table: slot registers, a bit-serial divider for the
// ms-to-tick conversion and a slot walker that visits one slot per cycle.
// Depends on cdt_pkg.
//
// Items that skip the walk go from ST_IDLE straight to ST_DONE; tick, close
// and read walk the slots in ST_SCAN, and open first runs the divider in ST_DIV
// (one quotient bit per cycle). Read and a reloading open stop at the first match.
// Only one item is in flight; the next beat can be taken while the previous
// result still waits in the output register. Reset clears
// every live bit and loads timers_enabled = 1 and tick_period_ms = 10.
module countdown_timer_slot_table_core #(
  parameter int unsigned SLOT_COUNT = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cdt_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cdt_pkg::out_beat_t out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [cdt_pkg::PeriodW-1:0] cfg_data_i
);
  import cdt_pkg::*;

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic                  enabled_q;
  logic [PeriodW-1:0]    period_q;

  action_e               act_q, act_d;
  logic [KeyW-1:0]       key_q, key_d;
  status_e               sts_q, sts_d;
  logic [CountW-1:0]     rem_q, rem_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [IdxW-1:0]       free_q, free_d;
  logic                  found_q, found_d;
  logic [DivW-1:0]       num_q, num_d;
  logic [PeriodW-1:0]    div_rem_q, div_rem_d;
  logic [DivCntW-1:0]    div_cnt_q, div_cnt_d;
  logic                  out_valid_q, out_valid_d;
  out_beat_t             out_data_q, out_data_d;

  logic [SLOT_COUNT-1:0] live_q;
  logic [KeyW-1:0]       key_mem [SLOT_COUNT];
  logic [CountW-1:0]     cnt_mem [SLOT_COUNT];
  logic [KeyW-1:0]       rd_key_q;
  logic [CountW-1:0]     rd_cnt_q;

  logic                  key_we, cnt_we, live_set, live_clr;
  logic [IdxW-1:0]       widx;
  logic [CountW-1:0]     cnt_wd;

  logic [PeriodW-1:0]    per_eff;
  logic [PeriodW:0]      trial;
  logic                  trial_ge;
  logic [CountW-1:0]     ticks;
  logic                  cur_live, cur_match, is_last;
  logic [KeyW-1:0]       cur_key;
  logic [CountW-1:0]     cur_cnt;

  assign per_eff   = (period_q == '0) ? PeriodW'(1) : period_q;
  assign trial     = {div_rem_q, num_q[DivW-1]};
  assign trial_ge  = trial >= {1'b0, per_eff};
  // Saturate the quotient; only reachable in principle, keeps the count bounded.
  assign ticks     = num_q[DivW-1] ? '1 : num_q[CountW-1:0];

  // Slot key and count are registered ahead, read at the next walk index.
  assign cur_live  = live_q[idx_q];
  assign cur_key   = rd_key_q;
  assign cur_cnt   = rd_cnt_q;
  assign cur_match = cur_live && (cur_key == key_q);
  assign is_last   = (idx_q == LastIdx);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    key_d       = key_q;
    sts_d       = sts_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    free_d      = free_q;
    found_d     = found_q;
    num_d       = num_q;
    div_rem_d   = div_rem_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    key_we      = 1'b0;
    cnt_we      = 1'b0;
    live_set    = 1'b0;
    live_clr    = 1'b0;
    widx        = idx_q;
    cnt_wd      = ticks;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          act_d     = in_data_i.action;
          key_d     = in_data_i.timer_key;
          sts_d     = STS_OK;
          rem_d     = '0;
          idx_d     = '0;
          found_d   = 1'b0;
          div_rem_d = '0;
          div_cnt_d = '0;
          // Round up: dividend = duration + period - 1.
          num_d     = DivW'(in_data_i.duration_ms) + DivW'(per_eff) - DivW'(1);
          case (in_data_i.action)
            ACT_TICK: begin
              state_d = enabled_q ? ST_SCAN : ST_DONE;
            end
            ACT_OPEN: begin
              if (in_data_i.timer_key == '0) begin
                sts_d   = STS_NULL_KEY;
                state_d = ST_DONE;
              end else if (in_data_i.duration_ms == '0) begin
                state_d = ST_DONE;
              end else begin
                state_d = ST_DIV;
              end
            end
            default: begin
              state_d = (in_data_i.timer_key == '0) ? ST_DONE : ST_SCAN;
            end
          endcase
        end
      end

      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        div_rem_d = trial_ge ? PeriodW'(trial - {1'b0, per_eff}) : trial[PeriodW-1:0];
        num_d     = {num_q[DivW-2:0], trial_ge};
        div_cnt_d = div_cnt_q + DivCntW'(1);
        if (div_cnt_q == DivCntW'(DivW - 1)) begin
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (is_last) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
        case (act_q)
          ACT_TICK: begin
            if (cur_live) begin
              cnt_we = 1'b1;
              cnt_wd = cur_cnt - CountW'(1);
              if (cur_cnt == CountW'(1)) begin
                live_clr = 1'b1;
              end
            end
          end
          ACT_OPEN: begin
            if (cur_match) begin
              cnt_we  = 1'b1;
              rem_d   = ticks;
              state_d = ST_DONE;
            end else begin
              if (!cur_live) begin
                free_d  = idx_q;
                found_d = 1'b1;
              end
              if (is_last) begin
                // Claim the highest free slot seen, this one included.
                if (!cur_live || found_q) begin
                  widx     = cur_live ? free_q : idx_q;
                  live_set = 1'b1;
                  key_we   = 1'b1;
                  cnt_we   = 1'b1;
                  rem_d    = ticks;
                end else begin
                  sts_d = STS_NO_SLOT;
                end
              end
            end
          end
          ACT_CLOSE: begin
            if (cur_match) begin
              live_clr = 1'b1;
            end
          end
          default: begin
            if (cur_match) begin
              rem_d   = cur_cnt;
              state_d = ST_DONE;
            end
          end
        endcase
      end

      ST_DONE: begin
        // Hold until the output register is free or drains this cycle.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d                = 1'b1;
          out_data_d.status          = sts_q;
          out_data_d.remaining_ticks = rem_q;
          state_d                    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      enabled_q   <= 1'b1;
      period_q    <= PeriodW'(10);
      live_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_TIMERS_ENABLED: enabled_q <= cfg_data_i[0];
          REG_TICK_PERIOD_MS: period_q  <= cfg_data_i;
          default:            period_q  <= period_q;
        endcase
      end
      if (live_set) begin
        live_q[widx] <= 1'b1;
      end
      if (live_clr) begin
        live_q[widx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    key_q      <= key_d;
    sts_q      <= sts_d;
    rem_q      <= rem_d;
    idx_q      <= idx_d;
    free_q     <= free_d;
    found_q    <= found_d;
    num_q      <= num_d;
    div_rem_q  <= div_rem_d;
    div_cnt_q  <= div_cnt_d;
    out_data_q <= out_data_d;
    rd_key_q   <= key_mem[idx_d];
    rd_cnt_q   <= cnt_mem[idx_d];
    if (key_we) begin
      key_mem[widx] <= key_q;
    end
    if (cnt_we) begin
      cnt_mem[widx] <= cnt_wd;
    end
  end

endmodule

// File: tb/sv/tb_countdown_timer_slot_table_core.sv
// Self-checking bench for countdown_timer_slot_table_core: a directed table, then random
// phases over register settings and handshake idling, each result checked against a typed
// value or a built-in predictor. Depends on cdt_pkg and the countdown_timer_slot_table_core RTL.
module tb_countdown_timer_slot_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cdt_pkg::*;

  localparam int unsigned SLOTS        = 20;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned DIR_ROWS     = 26;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_e;

  // Config rows carry the register index in key and the value in dur.
  typedef struct packed {
    row_kind_e   kind;
    action_e     act;
    logic [31:0] key;
    logic [31:0] dur;
    logic [4:0]  reps;
    logic        pinned;
    status_e     st;
    logic [31:0] rem;
  } row_t;

  localparam row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_ITEM, ACT_READ,  32'd5,         32'd0,         5'd1,  1'b1, STS_OK,       32'd0},
    '{ROW_ITEM, ACT_OPEN,  32'd0,         32'd100,       5'd1,  1'b1, STS_NULL_KEY, 32'd0},
    '{ROW_ITEM, ACT_OPEN,  32'd1,         32'd0,         5'd1,  1'b1, STS_OK,       32'd0},
    '{ROW_ITEM, ACT_OPEN,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1,  1'b1, STS_OK,
      32'd429496730},
    '{ROW_ITEM, ACT_OPEN,  32'd1,         32'd1,         5'd1,  1'b1, STS_OK,       32'd1},
    '{ROW_ITEM, ACT_OPEN,  32'd1,         32'd25,        5'd1,  1'b1, STS_OK,       32'd3},
    '{ROW_ITEM, ACT_READ,  32'd1,         32'd0,         5'd1,  1'b1, STS_OK,       32'd3},
    '{ROW_ITEM, ACT_TICK,  32'd0,         32'd0,         5'd1,  1'b1, STS_OK,       32'd0},
    '{ROW_ITEM, ACT_READ,  32'd1,         32'd0,         5'd1,  1'b1, STS_OK,       32'd2},
    '{ROW_ITEM, ACT_CLOSE, 32'd0,         32'd0,         5'd1,  1'b1, STS_OK,       32'd0},
    '{ROW_ITEM, ACT_READ,  32'd0,         32'd0,         5'd1,  1'b1, STS_OK,       32'd0},
    '{ROW_ITEM, ACT_CLOSE, 32'd1,         32'd0,         5'd1,  1'b1, STS_OK,       32'd0},
    '{ROW_ITEM, ACT_READ,  32'd1,         32'd0,         5'd1,  1'b1, STS_OK,       32'd0},
    '{ROW_ITEM, ACT_READ,  32'hFFFF_FFFF, 32'd0,         5'd1,  1'b0, STS_OK,       32'd0},
    // fill every remaining slot, then overflow, then reload while full
    '{ROW_ITEM, ACT_OPEN,  32'h100,       32'd30,        5'd19, 1'b0, STS_OK,       32'd0},
    '{ROW_ITEM, ACT_OPEN,  32'h200,       32'd5,         5'd1,  1'b1, STS_NO_SLOT,  32'd0},
    '{ROW_ITEM, ACT_OPEN,  32'h100,       32'd10,        5'd1,  1'b1, STS_OK,       32'd1},
    '{ROW_ITEM, ACT_TICK,  32'd0,         32'd0,         5'd3,  1'b0, STS_OK,       32'd0},
    '{ROW_ITEM, ACT_OPEN,  32'h200,       32'd5,         5'd1,  1'b1, STS_OK,       32'd1},
    // zero period counts as one; disabled timers ignore ticks
    '{ROW_CFG,  ACT_TICK,  32'(REG_TICK_PERIOD_MS), 32'd0, 5'd1, 1'b0, STS_OK,      32'd0},
    '{ROW_ITEM, ACT_OPEN,  32'd7,         32'd3,         5'd1,  1'b1, STS_OK,       32'd3},
    '{ROW_CFG,  ACT_TICK,  32'(REG_TIMERS_ENABLED), 32'd0, 5'd1, 1'b0, STS_OK,      32'd0},
    '{ROW_ITEM, ACT_TICK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd2,  1'b0, STS_OK,       32'd0},
    '{ROW_ITEM, ACT_READ,  32'd7,         32'd0,         5'd1,  1'b1, STS_OK,       32'd3},
    '{ROW_ITEM, ACT_CLOSE, 32'hFFFF_FFFF, 32'd0,         5'd1,  1'b1, STS_OK,       32'd0},
    '{ROW_ITEM, ACT_READ,  32'hFFFF_FFFF, 32'd0,         5'd1,  1'b1, STS_OK,       32'd0}
  };

  localparam logic [0:0] PH_ENABLE [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
  localparam int unsigned PH_PERIOD [PHASES] = '{10, 1, 1000, 1000, 1023, 0};
  localparam int unsigned PH_SEND   [PHASES] = '{11, 11, 86, 86, 0, 0};
  localparam int unsigned PH_RECV   [PHASES] = '{86, 86, 11, 11, 0, 0};

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_beat_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_beat_t          out_data;
  logic               cfg_we    = 1'b0;
  reg_idx_e           cfg_idx   = REG_TIMERS_ENABLED;
  logic [PeriodW-1:0] cfg_data  = '0;

  // Expected value typed in the directed table, travels with the beat.
  logic      pin_on   = 1'b0;
  out_beat_t pin_beat = '0;

  // Predicted slot bank and registers.
  logic               slot_on    [SLOTS];
  logic [KeyW-1:0]    slot_owner [SLOTS];
  logic [CountW-1:0]  slot_left  [SLOTS];
  logic               tick_enable;
  logic [PeriodW-1:0] tick_period;

  out_beat_t   pending_replies [$];
  logic [31:0] key_pool [POOL_SIZE];
  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 86;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;

  countdown_timer_slot_table_core #(.SLOT_COUNT(SLOTS)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [CountW-1:0] ms_to_ticks(logic [31:0] ms);
    logic [63:0] div, ticks;
    div   = (tick_period == '0) ? 64'd1 : 64'(tick_period);
    ticks = (64'(ms) + div - 64'd1) / div;
    return (ticks > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ticks[31:0];
  endfunction

  // Apply one request to the predicted bank and return the reply it yields.
  function automatic out_beat_t timer_bank_step(in_beat_t req);
    out_beat_t   rsp;
    int          free_idx, hit_idx;
    logic [31:0] ticks;
    rsp = '{status: STS_OK, remaining_ticks: '0};
    free_idx = -1;
    hit_idx  = -1;
    case (req.action)
      ACT_TICK: begin
        if (tick_enable) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_on[i]) begin
              slot_left[i] = slot_left[i] - 1;
              if (slot_left[i] == '0) slot_on[i] = 1'b0;
            end
          end
        end
      end
      ACT_OPEN: begin
        if (req.timer_key == '0) begin
          rsp.status = STS_NULL_KEY;
        end else if (req.duration_ms != '0) begin
          ticks = ms_to_ticks(req.duration_ms);
          for (int i = 0; i < SLOTS && hit_idx < 0; i++) begin
            if (!slot_on[i]) free_idx = i;
            else if (slot_owner[i] == req.timer_key) hit_idx = i;
          end
          if (hit_idx >= 0) begin
            slot_left[hit_idx]  = ticks;
            rsp.remaining_ticks = ticks;
          end else if (free_idx < 0) begin
            rsp.status = STS_NO_SLOT;
          end else begin
            slot_on[free_idx]    = 1'b1;
            slot_owner[free_idx] = req.timer_key;
            slot_left[free_idx]  = ticks;
            rsp.remaining_ticks  = ticks;
          end
        end
      end
      ACT_CLOSE: begin
        if (req.timer_key != '0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_on[i] && slot_owner[i] == req.timer_key) slot_on[i] = 1'b0;
          end
        end
      end
      default: begin
        if (req.timer_key != '0) begin
          for (int i = 0; i < SLOTS && hit_idx < 0; i++) begin
            if (slot_on[i] && slot_owner[i] == req.timer_key) hit_idx = i;
          end
          if (hit_idx >= 0) rsp.remaining_ticks = slot_left[hit_idx];
        end
      end
    endcase
    return rsp;
  endfunction

  // Mostly pool keys and short durations so slots fill, reload and expire.
  function automatic in_beat_t random_request();
    in_beat_t    req;
    int unsigned pick, span;
    span = (tick_period == '0) ? 1 : int'(tick_period);
    pick = $urandom_range(99);
    if (pick < 38)      req.action = ACT_OPEN;
    else if (pick < 63) req.action = ACT_TICK;
    else if (pick < 88) req.action = ACT_READ;
    else                req.action = ACT_CLOSE;
    pick = $urandom_range(99);
    if (pick < 84)      req.timer_key = key_pool[$urandom_range(POOL_SIZE - 1)];
    else if (pick < 95) req.timer_key = $urandom;
    else                req.timer_key = '0;
    pick = $urandom_range(99);
    if (pick < 72)      req.duration_ms = $urandom_range(5 * span, 1);
    else if (pick < 80) req.duration_ms = '0;
    else if (pick < 90) req.duration_ms = $urandom;
    else                req.duration_ms = 32'hFFFF_FFFF - $urandom_range(3000);
    return req;
  endfunction

  // Entered and left at a falling edge.
  task automatic send_beat(input in_beat_t req, input logic pinned, input out_beat_t typed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    pin_on   <= pinned;
    pin_beat <= typed;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  // Hold the sender until every outstanding reply has come back.
  task automatic wait_replies(input int unsigned settle);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [PeriodW-1:0] value);
    wait_replies(4);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    if (idx == REG_TIMERS_ENABLED) tick_enable = value[0];
    else tick_period = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : monitor
    out_beat_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected reply, status %0d ticks %0d", $time,
                   out_data.status, out_data.remaining_ticks);
        end else begin
          want = pending_replies.pop_front();
          if (out_data.status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d got %0d", $time, want.status, out_data.status);
          end
          if (out_data.remaining_ticks !== want.remaining_ticks) begin
            mismatches++;
            $display("%0t: remaining_ticks expected %0d got %0d", $time,
                     want.remaining_ticks, out_data.remaining_ticks);
          end
        end
      end
      // predict after the pop so a same-edge reply matches the older request
      if (in_valid && in_ready) begin
        want = timer_bank_step(in_data);
        pending_replies.push_back(pin_on ? pin_beat : want);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog, no beat for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    row_t        row;
    in_beat_t    req;
    out_beat_t   typed;
    logic [31:0] pool_key;
    int unsigned period;
    for (int i = 0; i < SLOTS; i++) begin
      slot_on[i]    = 1'b0;
      slot_owner[i] = '0;
      slot_left[i]  = '0;
    end
    tick_enable = 1'b1;
    tick_period = 10'd10;
    for (int i = 0; i < POOL_SIZE; i++) begin
      do pool_key = $urandom; while (pool_key == '0);
      key_pool[i] = pool_key;
    end

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.kind == ROW_CFG) begin
        write_reg(reg_idx_e'(row.key[0]), row.dur[PeriodW-1:0]);
      end else begin
        for (int n = 0; n < int'(row.reps); n++) begin
          req.action      = row.act;
          req.timer_key   = row.key + n;
          req.duration_ms = row.dur;
          typed.status    = row.st;
          typed.remaining_ticks = row.rem;
          send_beat(req, row.pinned, typed);
        end
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      period = (PH_PERIOD[ph] == 0) ? $urandom_range(999, 2) : PH_PERIOD[ph];
      write_reg(REG_TIMERS_ENABLED, PeriodW'(PH_ENABLE[ph]));
      write_reg(REG_TICK_PERIOD_MS, PeriodW'(period));
      send_idle_pct = PH_SEND[ph];
      recv_idle_pct = PH_RECV[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_replies(0);
        send_beat(random_request(), 1'b0, '0);
      end
    end

    wait_replies(DRAIN_CYCLES);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cdt_pkg.sv
rtl/countdown_timer_slot_table_core.sv
tb/sv/tb_countdown_timer_slot_table_core.sv
